FILE: design/bsot_pkg.sv
// Shared types and constants for the bus slot occupancy tracker.
`default_nettype none
package bsot_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [2:0] {
		K_CLEAR = 3'd0,
		K_POLL  = 3'd1,
		K_TOKEN = 3'd2,
		K_EMIT  = 3'd3,
		K_QUERY = 3'd4,
		K_NTH   = 3'd5,
		K_RAND  = 3'd6,
		K_OWN   = 3'd7
	} kind_t;

	// Configuration register indexes
	localparam logic [1:0] REG_RESERVED = 2'd0;
	localparam logic [1:0] REG_NO_TOKEN = 2'd1;
	localparam logic [1:0] REG_SLOT     = 2'd2;

	// Register reset values
	localparam logic [6:0] RESERVED_RST = 7'd32;
	localparam logic [9:0] NO_TOKEN_RST = 10'd500;
	localparam logic [6:0] SLOT_RST     = 7'd10;

	// Slot flag bits
	localparam int FLAG_W   = 4;
	localparam int F_POLL_B = 0;
	localparam int F_EMIT_B = 1;
	localparam int F_TOK_B  = 2;
	localparam int F_RSV_B  = 3;
	localparam logic [FLAG_W-1:0] F_POLL = 4'b0001;
	localparam logic [FLAG_W-1:0] F_EMIT = 4'b0010;
	localparam logic [FLAG_W-1:0] F_TOK  = 4'b0100;
	localparam logic [FLAG_W-1:0] F_RSV  = 4'b1000;

	localparam logic [7:0]  NONE_SLOT = 8'hFF;
	localparam logic [15:0] SIL_MAX   = 16'hFFFF;

	// Shared remainder unit
	localparam int DIV_DW    = 16;
	localparam int DIV_RW    = 9;
	localparam int DIV_STEPS = DIV_DW;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_RW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_RW-1:0] rem;
	} div_rsp_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_OWN_GO,
		ST_OWN_WAIT,
		ST_MUL,
		ST_SIL,
		ST_RD,
		ST_WR,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_EVAL,
		ST_RND_GO,
		ST_RND_WAIT,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

FILE: design/bsot_div.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module bsot_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bsot_pkg::div_req_t req,
	output bsot_pkg::div_rsp_t      rsp
);
	import bsot_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] dvd_q;
	logic [DIV_RW-1:0] dvs_q;
	logic [DIV_RW-1:0] rem_q;
	logic [DIV_RW:0]   trial;
	logic [DIV_RW:0]   diff;

	// trial remainder with the next dividend bit shifted in
	assign trial = {rem_q, dvd_q[DIV_DW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DW-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q})
				rem_q <= diff[DIV_RW-1:0];
			else
				rem_q <= trial[DIV_RW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

FILE: design/bus_slot_occupancy_tracker.sv
// Top level: slot flag table, scan sequencer and output register.
//
// Tracks the free station addresses of a token bus. Input beats on the s_ side
// carry the item kind in s_tuser and address, rank and random word in s_tdata;
// each beat yields exactly one result beat on the m_ side. The user must write
// configuration on cfg_we/cfg_index/cfg_data only while the block is idle; the
// block itself does not enforce this. An item is handled by a sequencer around
// one shared 16-bit remainder unit and a sweep of the flag table, one slot a
// cycle through the single read port of the flag memory. Queries, rank picks
// and own address take one sweep; in-range mark events first update their entry;
// clear items take a remainder for the own address (none when no slot is
// unreserved) before their sweep; a random pick sweeps, takes a remainder and
// sweeps again (one sweep when no slot is free). s_tready is high only when
// idle, so an item is accepted only after the previous result is loaded into
// the output register. Reset clears the table by valid bits (reserved below 32),
// sets the own address to 32 and its silence time from the reset registers; no
// sweep is needed after reset. A clear item drops all valid bits at once. A
// finished result waits in the output register; the next item is accepted
// meanwhile, and its own result is held back until the register is taken.
`default_nettype none
module bus_slot_occupancy_tracker #(
	parameter int SLOTS = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // slot_address, free_rank, random_word
	input  wire logic [2:0]  s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// next token holder, free_count, picked_slot, address_free, cycle_complete,
	// own_address, own_time_slot, zero fill
	output logic [55:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);
	import bsot_pkg::*;

	localparam int IW      = $clog2(SLOTS);
	localparam int SIL_RAW = 500 + (SLOTS + 32) * 10;
	localparam int SIL_RST = (SIL_RAW > 65535) ? 65535 : SIL_RAW;

	// configuration
	logic [6:0] rsv_cnt_q;
	logic [9:0] no_tok_q;
	logic [6:0] slot_tm_q;

	// sequencer and item
	state_t      state_q, state_nxt;
	kind_t       kind_q;
	logic [7:0]  addr_q;
	logic [8:0]  target_q;
	logic [15:0] rnd_q;
	logic        pass2_q;
	logic        in_range;

	// persistent state
	logic [7:0]  own_q;
	logic [15:0] sil_q;
	logic        poll_done_q;
	logic [6:0]  rc_clr_q;
	logic [16:0] prod_q;
	logic        poll_old_q;
	logic [IW-1:0] s0_q;
	logic [8:0]  wrap_v;

	// flag memory with valid bits
	logic [FLAG_W-1:0] flag_mem [SLOTS];
	logic [SLOTS-1:0]  fvld_q;
	logic              mem_rd, mem_we, clr_all;
	logic [IW-1:0]     raddr, waddr;
	logic [FLAG_W-1:0] wdata;
	logic [FLAG_W-1:0] rd_data_s1;
	logic              rd_fvld_s1;
	logic [IW-1:0]     idx_s1;
	logic              scan_rd;
	logic              pend_s1;
	logic [FLAG_W-1:0] eff_flags;
	logic [FLAG_W-1:0] mark;

	// sweep accumulators
	logic [IW-1:0] scan_q;
	logic [8:0]    cnt_q;
	logic          found_q, tge_q, tany_q, afree_q;
	logic [IW-1:0] pick_q, tge_idx_q, tany_idx_q;
	logic          slot_free;

	// remainder unit
	div_req_t div_req;
	div_rsp_t div_rsp;

	// output
	logic        m_vld_q;
	logic [55:0] m_data_q;
	logic        out_load;
	logic        poll_nxt;
	logic [7:0]  next_o, pick_o;
	logic [17:0] sil_sum;

	bsot_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_range = ({1'b0, addr_q} < 9'(SLOTS));

	// start of the token search: slot_address+1 folded into the table
	always_comb begin
		wrap_v = {1'b0, addr_q} + 9'd1;
		for (int j = 5; j >= 0; j--) begin
			if (32'(wrap_v) >= 32'(SLOTS << j))
				wrap_v = wrap_v - 9'(SLOTS << j);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_cnt_q <= RESERVED_RST;
			no_tok_q  <= NO_TOKEN_RST;
			slot_tm_q <= SLOT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESERVED: rsv_cnt_q <= cfg_data[6:0];
				REG_NO_TOKEN: no_tok_q  <= cfg_data;
				REG_SLOT:     slot_tm_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// next state and strobes
	always_comb begin
		state_nxt = state_q;
		div_req   = '0;
		mem_rd    = 1'b0;
		scan_rd   = 1'b0;
		raddr     = scan_q;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_nxt = ST_DECODE;
			end
			ST_DECODE: begin
				priority if (kind_q == K_CLEAR)
					state_nxt = (9'(rsv_cnt_q) < 9'(SLOTS)) ? ST_OWN_GO : ST_MUL;
				else if ((kind_q == K_POLL || kind_q == K_TOKEN || kind_q == K_EMIT)
						&& in_range)
					state_nxt = ST_RD;
				else
					state_nxt = ST_SCAN_INIT;
			end
			ST_OWN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = rnd_q;
				div_req.divisor  = 9'(SLOTS) - 9'(rsv_cnt_q);
				state_nxt        = ST_OWN_WAIT;
			end
			ST_OWN_WAIT: begin
				if (div_rsp.done)
					state_nxt = ST_MUL;
			end
			ST_MUL: state_nxt = ST_SIL;
			ST_SIL: state_nxt = ST_SCAN_INIT;
			ST_RD: begin
				mem_rd    = 1'b1;
				raddr     = addr_q[IW-1:0];
				state_nxt = ST_WR;
			end
			ST_WR: state_nxt = ST_SCAN_INIT;
			ST_SCAN_INIT: state_nxt = ST_SCAN;
			ST_SCAN: begin
				mem_rd  = 1'b1;
				scan_rd = 1'b1;
				if (scan_q == IW'(SLOTS - 1))
					state_nxt = ST_SCAN_END;
			end
			ST_SCAN_END: state_nxt = ST_EVAL;
			ST_EVAL: begin
				if (kind_q == K_RAND && !pass2_q && cnt_q != 9'd0)
					state_nxt = ST_RND_GO;
				else
					state_nxt = ST_FIN;
			end
			ST_RND_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = rnd_q;
				div_req.divisor  = cnt_q;
				state_nxt        = ST_RND_WAIT;
			end
			ST_RND_WAIT: begin
				if (div_rsp.done)
					state_nxt = ST_SCAN_INIT;
			end
			ST_FIN: begin
				if (!m_vld_q || m_tready) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// effective flags of the entry just read; unwritten entries read as cleared
	assign eff_flags = rd_fvld_s1 ? rd_data_s1 :
		((9'(idx_s1) < 9'(rc_clr_q)) ? F_RSV : '0);
	assign slot_free = (eff_flags == F_POLL);

	always_comb begin
		unique case (kind_q)
			K_POLL:  mark = F_POLL;
			K_TOKEN: mark = F_TOK;
			K_EMIT:  mark = F_EMIT;
			default: mark = '0;
		endcase
	end

	assign mem_we  = (state_q == ST_WR);
	assign waddr   = addr_q[IW-1:0];
	assign wdata   = eff_flags | mark;
	assign clr_all = (state_q == ST_DECODE) && (kind_q == K_CLEAR);

	// flag memory
	always_ff @(posedge clk) begin
		if (mem_we)
			flag_mem[waddr] <= wdata;
		if (mem_rd) begin
			rd_data_s1 <= flag_mem[raddr];
			rd_fvld_s1 <= fvld_q[raddr];
			idx_s1     <= raddr;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fvld_q <= '0;
		else if (clr_all)
			fvld_q <= '0;
		else if (mem_we)
			fvld_q[waddr] <= 1'b1;
	end

	// second-pass flag, cleared reserved count, own address, silence time and poll cycle flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= 8'(RESERVED_RST);
			sil_q       <= 16'(SIL_RST);
			poll_done_q <= 1'b0;
			rc_clr_q    <= RESERVED_RST;
			pass2_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						pass2_q <= 1'b0;
				end
				ST_DECODE: begin
					if (kind_q == K_CLEAR) begin
						rc_clr_q    <= rsv_cnt_q;
						poll_done_q <= 1'b0;
						own_q       <= {1'b0, rsv_cnt_q};
					end
					if (kind_q == K_OWN)
						own_q <= addr_q;
				end
				ST_OWN_WAIT: begin
					if (div_rsp.done)
						own_q <= 8'(9'(rsv_cnt_q) + div_rsp.rem);
				end
				ST_SIL: sil_q <= (sil_sum > 18'(SIL_MAX)) ? SIL_MAX : sil_sum[15:0];
				ST_RND_WAIT: begin
					if (div_rsp.done)
						pass2_q <= 1'b1;
				end
				ST_FIN: begin
					if (out_load)
						poll_done_q <= poll_nxt;
				end
				default: ;
			endcase
		end
	end

	assign sil_sum = 18'(no_tok_q) + 18'(prod_q);

	// item payload and per-item working values
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			kind_q   <= kind_t'(s_tuser);
			addr_q   <= s_tdata[7:0];
			target_q <= {1'b0, s_tdata[15:8]};
			rnd_q    <= s_tdata[31:16];
		end
		if (state_q == ST_DECODE)
			s0_q <= wrap_v[IW-1:0];
		if (state_q == ST_MUL)
			prod_q <= (17'(SLOTS) + 17'(own_q)) * 17'(slot_tm_q);
		if (state_q == ST_WR)
			poll_old_q <= eff_flags[F_POLL_B];
		if (state_q == ST_RND_WAIT && div_rsp.done)
			target_q <= div_rsp.rem;
	end

	// sweep over the table, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			scan_q  <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			tge_q   <= 1'b0;
			tany_q  <= 1'b0;
			afree_q <= 1'b0;
		end else begin
			pend_s1 <= scan_rd;
			if (state_q == ST_SCAN_INIT) begin
				scan_q  <= '0;
				cnt_q   <= '0;
				found_q <= 1'b0;
				tge_q   <= 1'b0;
				tany_q  <= 1'b0;
				afree_q <= 1'b0;
			end else begin
				if (scan_rd)
					scan_q <= scan_q + 1'b1;
				if (pend_s1) begin
					if (slot_free) begin
						cnt_q <= cnt_q + 9'd1;
						if (!found_q && cnt_q == target_q)
							found_q <= 1'b1;
					end
					if (eff_flags[F_TOK_B]) begin
						tany_q <= 1'b1;
						if (idx_s1 >= s0_q)
							tge_q <= 1'b1;
					end
					if (8'(idx_s1) == addr_q)
						afree_q <= slot_free;
				end
			end
		end
	end

	// sweep indexes
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			if (slot_free && !found_q && cnt_q == target_q)
				pick_q <= idx_s1;
			if (eff_flags[F_TOK_B]) begin
				if (!tany_q)
					tany_idx_q <= idx_s1;
				if (!tge_q && idx_s1 >= s0_q)
					tge_idx_q <= idx_s1;
			end
		end
	end

	// result fields
	always_comb begin
		priority if (tge_q)
			next_o = 8'(tge_idx_q);
		else if (tany_q)
			next_o = 8'(tany_idx_q);
		else
			next_o = NONE_SLOT;
		if (found_q && (kind_q == K_NTH || (kind_q == K_RAND && pass2_q)))
			pick_o = 8'(pick_q);
		else
			pick_o = NONE_SLOT;
		poll_nxt = poll_done_q ||
			(kind_q == K_POLL && in_range && poll_old_q && cnt_q != 9'd0);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_vld_q <= 1'b0;
		else if (out_load)
			m_vld_q <= 1'b1;
		else if (m_tready)
			m_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_data_q <= {5'b0, sil_q, own_q, poll_nxt, afree_q, pick_o, cnt_q, next_o};
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

FILE: tb/bus_slot_occupancy_tracker_tb.sv
// Self-checking testbench for the bus slot occupancy tracker.
module bus_slot_occupancy_tracker_tb;
	import bsot_pkg::*;

	localparam int SLOTS = 128;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 64;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// result beat layout, top bit first (packed struct order)
	typedef struct packed {
		logic [4:0]  pad;
		logic [15:0] time_slot;
		logic [7:0]  own;
		logic        cyc;
		logic        addr_free;
		logic [7:0]  picked;
		logic [8:0]  free_cnt;
		logic [7:0]  next_st;
	} result_t;

	// Shadow of the slot table; predicts each result beat and checks it
	class occupancy_scoreboard;
		logic [FLAG_W-1:0] flags [SLOTS];
		int unsigned rsv_count, no_token_ms, slot_ms;
		logic [7:0]  own_addr;
		logic [15:0] silence;
		bit          cyc_done;
		result_t     pending_results [$];
		int          errors, items_seen, results_seen, picks_found, cyc_hits;
		int          kind_hits [8];

		function new();
			rsv_count   = RESERVED_RST;
			no_token_ms = NO_TOKEN_RST;
			slot_ms     = SLOT_RST;
			clear_table(16'd0);
		endfunction

		function void set_reg(logic [1:0] idx, logic [9:0] value);
			case (idx)
				REG_RESERVED: rsv_count = value[6:0];
				REG_NO_TOKEN: no_token_ms = value;
				REG_SLOT:     slot_ms = value[6:0];
				default: ;
			endcase
		endfunction

		function bit slot_free(int unsigned s);
			if (s >= SLOTS) return 1'b0;
			return flags[s] == F_POLL;
		endfunction

		function int unsigned count_free();
			int unsigned n;
			n = 0;
			for (int i = 0; i < SLOTS; i++)
				if (slot_free(i)) n++;
			return n;
		endfunction

		function logic [7:0] nth_free(int unsigned rank);
			int unsigned seen;
			seen = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_free(i)) begin
					if (seen == rank) return 8'(i);
					seen++;
				end
			end
			return NONE_SLOT;
		endfunction

		// first token holder after addr, wrapping round the table
		function logic [7:0] next_token(logic [7:0] addr);
			int unsigned s;
			s = (addr + 1) % SLOTS;
			for (int i = 0; i < SLOTS; i++) begin
				if (flags[s][F_TOK_B]) return 8'(s);
				s = (s + 1) % SLOTS;
			end
			return NONE_SLOT;
		endfunction

		// table wipe, reserved marks, random own address and its silence time
		function void clear_table(logic [15:0] rnd);
			int unsigned t;
			for (int i = 0; i < SLOTS; i++)
				flags[i] = (i < rsv_count) ? F_RSV : '0;
			if (rsv_count < SLOTS)
				own_addr = 8'(rsv_count + rnd % (SLOTS - rsv_count));
			else
				own_addr = 8'(rsv_count);
			t = no_token_ms + SLOTS * slot_ms + own_addr * slot_ms;
			silence = (t > 65535) ? SIL_MAX : 16'(t);
			cyc_done = 1'b0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_item(kind_t k, logic [7:0] addr, logic [7:0] rank,
				logic [15:0] rnd);
			result_t r;
			int unsigned n;
			logic [7:0] picked;
			picked = NONE_SLOT;
			items_seen++;
			kind_hits[k]++;
			case (k)
				K_CLEAR: clear_table(rnd);
				K_POLL: begin
					if (addr < SLOTS) begin
						if (flags[addr][F_POLL_B] && count_free() > 0) cyc_done = 1'b1;
						flags[addr] |= F_POLL;
					end
				end
				K_TOKEN: if (addr < SLOTS) flags[addr] |= F_TOK;
				K_EMIT:  if (addr < SLOTS) flags[addr] |= F_EMIT;
				K_NTH:   picked = nth_free(rank);
				K_RAND: begin
					n = count_free();
					if (n > 0) picked = nth_free(rnd % n);
				end
				K_OWN:   own_addr = addr;
				default: ;
			endcase
			if (picked != NONE_SLOT) picks_found++;
			if (cyc_done) cyc_hits++;
			r           = '0;
			r.next_st   = next_token(addr);
			r.free_cnt  = 9'(count_free());
			r.picked    = picked;
			r.addr_free = slot_free(addr);
			r.cyc       = cyc_done;
			r.own       = own_addr;
			r.time_slot = silence;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [55:0] data);
			result_t got, want;
			got = data;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, expected nothing actual %h",
					$time, data);
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			compare_field("next_token", want.next_st, got.next_st);
			compare_field("free_count", want.free_cnt, got.free_cnt);
			compare_field("picked_slot", want.picked, got.picked);
			compare_field("address_free", want.addr_free, got.addr_free);
			compare_field("cycle_complete", want.cyc, got.cyc);
			compare_field("own_address", want.own, got.own);
			compare_field("own_time_slot", want.time_slot, got.time_slot);
			compare_field("zero fill", want.pad, got.pad);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // slot_address, free_rank, random_word
	logic [2:0]  s_tuser;  // kind
	logic        m_tvalid;
	logic        m_tready;
	// next token holder, free_count, picked_slot, address_free, cycle_complete,
	// own_address, own_time_slot, zero fill
	logic [55:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;

	occupancy_scoreboard sb;
	bit no_idle;

	bus_slot_occupancy_tracker #(.SLOTS(SLOTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// beats and register writes as the block sees them
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(kind_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[31:16]);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (cfg_we) sb.set_reg(cfg_index, cfg_data);
		end
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	// result side: random stall before each beat
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// present one item at a falling edge, hold until taken, then idle a while
	task automatic send_item(kind_t k, logic [7:0] addr, logic [7:0] rank,
			logic [15:0] rnd);
		int gap;
		s_tuser  = k;
		s_tdata  = {rnd, rank, addr};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] value);
		cfg_index = idx;
		cfg_data  = value;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(logic [9:0] rsv, logic [9:0] no_tok, logic [9:0] slot_ms);
		write_reg(REG_RESERVED, rsv);
		write_reg(REG_NO_TOKEN, no_tok);
		write_reg(REG_SLOT, slot_ms);
	endtask

	// drop valid and wait for every outstanding result
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		int p, item_no;
		kind_t k;
		logic [7:0] addr, rank;
		logic [15:0] rnd;
		sb        = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = K_QUERY;
		cfg_we    = 1'b0;
		cfg_index = REG_RESERVED;
		cfg_data  = '0;
		no_idle   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset table, edge addresses, every kind
		send_item(K_QUERY, 8'd0, 8'd0, 16'd0);        // reserved, never polled
		send_item(K_QUERY, 8'd255, 8'hFF, 16'hFFFF);  // out of range, scan from 0
		send_item(K_POLL, 8'd40, 8'd0, 16'd0);
		send_item(K_POLL, 8'd40, 8'd0, 16'd0);        // repeat poll: cycle complete
		send_item(K_POLL, 8'd41, 8'd0, 16'd0);
		send_item(K_TOKEN, 8'd41, 8'd0, 16'd0);
		send_item(K_POLL, 8'd42, 8'd0, 16'd0);
		send_item(K_EMIT, 8'd42, 8'd0, 16'd0);
		send_item(K_QUERY, 8'd127, 8'd0, 16'd0);      // token search wraps
		send_item(K_POLL, 8'd127, 8'd0, 16'd0);
		send_item(K_NTH, 8'd0, 8'd0, 16'd0);
		send_item(K_NTH, 8'd40, 8'd255, 16'd0);       // rank past the end
		send_item(K_RAND, 8'd127, 8'd0, 16'hFFFF);
		send_item(K_POLL, 8'd200, 8'd0, 16'd0);       // out of range marks ignored
		send_item(K_TOKEN, 8'd255, 8'd0, 16'd0);
		send_item(K_EMIT, 8'd128, 8'd0, 16'd0);
		send_item(K_OWN, 8'd255, 8'd0, 16'd0);        // no range check
		send_item(K_OWN, 8'd0, 8'd0, 16'd0);
		send_item(K_POLL, 8'd10, 8'd0, 16'd0);        // reserved slot stays taken
		send_item(K_CLEAR, 8'd0, 8'd0, 16'hFFFF);
		send_item(K_NTH, 8'd0, 8'd0, 16'd0);          // empty table
		send_item(K_RAND, 8'd0, 8'd0, 16'h1234);
		wait_drained();

		// reserved count only takes effect at the next clear
		write_reg(REG_RESERVED, 10'd0);
		write_reg(REG_UNUSED, 10'h3FF);
		send_item(K_POLL, 8'd5, 8'd0, 16'd0);
		send_item(K_CLEAR, 8'd0, 8'd0, 16'd0);
		send_item(K_POLL, 8'd5, 8'd0, 16'd0);

		// random phases, each under its own register setting
		item_no = 0;
		for (int phase = 1; phase <= 6; phase++) begin
			wait_drained();
			case (phase)
				1: configure(10'd0, 10'd0, 10'd0);
				2: configure(10'd127, 10'd1000, 10'd100);
				3: configure(10'd1, 10'd1023, 10'd127);
				default: configure(10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
			endcase
			if (phase != 5) send_item(K_CLEAR, 8'd0, 8'd0, 16'($urandom_range(0, 65535)));
			for (int i = 0; i < 137; i++) begin
				no_idle = ((item_no / 40) % 5 == 4);
				item_no++;
				p = $urandom_range(0, 99);
				if ($urandom_range(0, 99) < 85)
					addr = 8'($urandom_range(0, SLOTS - 1));
				else
					addr = 8'($urandom_range(SLOTS, 255));
				rank = 8'($urandom_range(0, 255));
				rnd  = 16'($urandom_range(0, 65535));
				if (p < 3)       k = K_CLEAR;
				else if (p < 38) k = K_POLL;
				else if (p < 46) k = K_TOKEN;
				else if (p < 54) k = K_EMIT;
				else if (p < 64) k = K_QUERY;
				else if (p < 77) k = K_NTH;
				else if (p < 90) k = K_RAND;
				else             k = K_OWN;
				// mostly ranks that land on a free slot
				if (k == K_NTH && $urandom_range(0, 3) != 0)
					rank = 8'($urandom_range(0, sb.count_free() + 1));
				send_item(k, addr, rank, rnd);
			end
		end

		wait_drained();
		no_idle = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived", $time, sb.pending());
		end
		$display("Covered %0d items, %0d results checked: %0d clears, %0d polls, %0d picks",
			sb.items_seen, sb.results_seen, sb.kind_hits[K_CLEAR], sb.kind_hits[K_POLL],
			sb.kind_hits[K_NTH] + sb.kind_hits[K_RAND]);
		$display("Picks that found a slot: %0d; results with cycle complete set: %0d",
			sb.picks_found, sb.cyc_hits);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#15000000;
		$display("Timeout with %0d results outstanding", sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
